// ----- rtl/core/biso_pkg.sv -----
// Shared types and constants of the brush isovalue block.
package biso_pkg;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_FORM_MODE    = 3'd0;
  localparam logic [2:0] REG_CENTER_X     = 3'd1;
  localparam logic [2:0] REG_CENTER_Y     = 3'd2;
  localparam logic [2:0] REG_CENTER_Z     = 3'd3;
  localparam logic [2:0] REG_BRUSH_RADIUS = 3'd4;
  localparam logic [2:0] REG_GAIN         = 3'd5;

  // Brush forms
  localparam logic FORM_SPHERE = 1'b0;
  localparam logic FORM_BOX    = 1'b1;

  // Result codes
  localparam logic signed [7:0] ISO_MAX    = 8'sd127;
  localparam logic signed [7:0] ISO_MIN    = -8'sd127;
  localparam logic signed [7:0] ISO_BOX_IN = -8'sd1;
  localparam logic signed [7:0] ISO_ZERO   = 8'sd0;

  // Far limit on any axis offset, as a bit position in Q.4
  localparam int FAR_BIT = 22;

  // Per-item side flags that travel beside the square-root datapath
  typedef struct packed {
    logic box;     // box form selected
    logic in_box;  // strictly inside the box on all axes
    logic far;     // some axis offset reached the far limit
  } biso_flags_t;

endpackage

// ----- rtl/core/biso_sqrt.sv -----
// Pipelined integer square root, one result bit per register stage.
module biso_sqrt import biso_pkg::*; #(
  parameter int RAD_BITS = 42,
  localparam int ROOT_BITS = RAD_BITS / 2
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  logic [RAD_BITS-1:0]  rad,
  input  biso_flags_t          in_flags,
  output logic                 in_ready,
  output logic                 out_valid,
  output logic [ROOT_BITS-1:0] root,
  output biso_flags_t          out_flags,
  input  logic                 out_ready
);

  logic                 v      [ROOT_BITS];
  logic [RAD_BITS-1:0]  rad_q  [ROOT_BITS];
  logic [ROOT_BITS:0]   rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];
  biso_flags_t          flg_q  [ROOT_BITS];
  logic                 rdy    [ROOT_BITS+1];

  assign rdy[ROOT_BITS] = out_ready;
  assign in_ready       = rdy[0];

  for (genvar j = 0; j < ROOT_BITS; j++) begin : g_stage
    logic                 prev_v;
    logic [RAD_BITS-1:0]  prev_rad;
    logic [ROOT_BITS:0]   prev_rem;
    logic [ROOT_BITS-1:0] prev_root;
    biso_flags_t          prev_flg;
    logic [ROOT_BITS+2:0] cat;
    logic [ROOT_BITS+2:0] trial;
    logic [ROOT_BITS+2:0] diff;
    logic                 ge;

    if (j == 0) begin : g_first
      assign prev_v    = in_valid;
      assign prev_rad  = rad;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_flg  = in_flags;
    end else begin : g_next
      assign prev_v    = v[j-1];
      assign prev_rad  = rad_q[j-1];
      assign prev_rem  = rem_q[j-1];
      assign prev_root = root_q[j-1];
      assign prev_flg  = flg_q[j-1];
    end

    // Bring down the next two radicand bits and try the next root bit
    assign cat   = {prev_rem, prev_rad[RAD_BITS-1 -: 2]};
    assign trial = {1'b0, prev_root, 2'b01};
    assign ge    = (cat >= trial);
    assign diff  = cat - trial;
    assign rdy[j] = !v[j] || rdy[j+1];

    always_ff @(posedge clk) begin
      if (rst) begin
        v[j] <= 1'b0;
      end else if (rdy[j]) begin
        v[j] <= prev_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[j]) begin
        rad_q[j]  <= prev_rad << 2;
        rem_q[j]  <= ge ? diff[ROOT_BITS:0] : cat[ROOT_BITS:0];
        root_q[j] <= (prev_root << 1) | ROOT_BITS'(ge);
        flg_q[j]  <= prev_flg;
      end
    end
  end

  assign out_valid = v[ROOT_BITS-1];
  assign root      = root_q[ROOT_BITS-1];
  assign out_flags = flg_q[ROOT_BITS-1];

endmodule

// ----- rtl/core/brush_isovalue_top.sv -----
// Top level of the brush isovalue block: config registers and sample pipeline.
//
// Use: program the brush through the write port (cfg_we, cfg_index, cfg_data)
// while no sample is in flight, then stream sample points px/py/pz on the
// input channel. Each transfer yields exactly one isovalue iso on the output
// channel, in order. A transfer happens on a rising edge with valid high and
// stall low.
// Sphere form: iso = (floor distance - radius) * gain, truncated toward zero
// and saturated to -127..127. Box form: -1 strictly inside the cube, else 127.
// Throughput: one sample per cycle while out_stall is low. Depth:
// min(COORD_BITS,22)+13 register stages (29 at COORD_BITS = 16). The square
// root sets the depth with one root bit per stage (min(COORD_BITS,22)+5
// stages); offsets, magnitudes, squares, sum, radius subtraction, gain
// multiply and truncation take one stage each, then the output register.
// Reset (rst, synchronous) empties every stage and the output register and
// loads the register reset values; gain resets to all ones.
// When the receiver stalls, the result holds in the output register while
// each upstream stage keeps filling until it meets a held item, so in_stall
// rises only once the whole pipeline is full.
module brush_isovalue_top import biso_pkg::*; #(
  parameter int COORD_BITS = 16,
  localparam int CFG_BITS = (COORD_BITS > 16) ? COORD_BITS : 16
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration write port
  input  logic                         cfg_we,
  input  logic [2:0]                   cfg_index,
  input  logic [CFG_BITS-1:0]          cfg_data,
  // sample input channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] px,
  input  logic signed [COORD_BITS-1:0] py,
  input  logic signed [COORD_BITS-1:0] pz,
  // isovalue output channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [7:0]            iso
);

  localparam int N         = COORD_BITS;
  // magnitude bits kept for the squares; larger offsets are far anyway
  localparam int MAG_BITS  = (N > FAR_BIT) ? FAR_BIT : N;
  localparam int CMP_BITS  = (N > 16) ? N : 16;
  localparam int SUM_BITS  = 2 * MAG_BITS + 2;
  localparam int RAD_BITS  = SUM_BITS + 8;
  localparam int ROOT_BITS = RAD_BITS / 2;
  localparam int DIFF_BITS = ((ROOT_BITS > 20) ? ROOT_BITS : 20) + 1;
  localparam int PROD_BITS = DIFF_BITS + 17;
  localparam int Q_BITS    = PROD_BITS - 16;

  localparam logic signed [Q_BITS-1:0] Q_MAX = Q_BITS'(ISO_MAX);
  localparam logic signed [Q_BITS-1:0] Q_MIN = Q_BITS'(ISO_MIN);

  // ---------------------------------------------------------------- registers
  logic                 form_mode;
  logic signed [N-1:0]  center_x;
  logic signed [N-1:0]  center_y;
  logic signed [N-1:0]  center_z;
  logic [15:0]          brush_radius;
  logic [15:0]          gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      form_mode    <= FORM_SPHERE;
      center_x     <= '0;
      center_y     <= '0;
      center_z     <= '0;
      brush_radius <= '0;
      gain         <= 16'hFFFF;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FORM_MODE:    form_mode    <= cfg_data[0];
        REG_CENTER_X:     center_x     <= cfg_data[N-1:0];
        REG_CENTER_Y:     center_y     <= cfg_data[N-1:0];
        REG_CENTER_Z:     center_z     <= cfg_data[N-1:0];
        REG_BRUSH_RADIUS: brush_radius <= cfg_data[15:0];
        REG_GAIN:         gain         <= cfg_data[15:0];
        default: ;  // drop writes to unknown indexes
      endcase
    end
  end

  // ------------------------------------------------------------ ready chain
  // A stage loads when it is empty or its item moves on in the same cycle.
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, rdy7, rdy_out;
  logic v1, v2, v3, v4, v5, v6, v7;
  logic sq_in_ready;
  logic sq_valid;

  assign rdy_out  = !out_valid || !out_stall;
  assign rdy7     = !v7 || rdy_out;
  assign rdy6     = !v6 || rdy7;
  assign rdy5     = !v5 || rdy6;
  assign rdy4     = !v4 || sq_in_ready;
  assign rdy3     = !v3 || rdy4;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_stall = !rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1)    v1        <= in_valid;
      if (rdy2)    v2        <= v1;
      if (rdy3)    v3        <= v2;
      if (rdy4)    v4        <= v3;
      if (rdy5)    v5        <= sq_valid;
      if (rdy6)    v6        <= v5;
      if (rdy7)    v7        <= v6;
      if (rdy_out) out_valid <= v7;
    end
  end

  // ------------------------------------------------- stage 1: axis offsets
  logic signed [N:0] s1_d [3];
  logic              s1_box;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_d[0] <= (N+1)'(px) - (N+1)'(center_x);
      s1_d[1] <= (N+1)'(py) - (N+1)'(center_y);
      s1_d[2] <= (N+1)'(pz) - (N+1)'(center_z);
      s1_box  <= (form_mode == FORM_BOX);
    end
  end

  // -------------------------------- stage 2: magnitudes, far and box tests
  logic [N-1:0] mag      [3];
  logic [2:0]   axis_in;
  logic [2:0]   axis_far;
  logic [N:0]   neg_d    [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      neg_d[a]   = -s1_d[a];
      mag[a]     = s1_d[a][N] ? neg_d[a][N-1:0] : s1_d[a][N-1:0];
      // strictly inside on this axis when |offset| < half-size
      axis_in[a] = (CMP_BITS'(mag[a]) < CMP_BITS'(brush_radius));
    end
  end

  if (N > FAR_BIT) begin : g_far
    always_comb begin
      for (int a = 0; a < 3; a++) begin
        axis_far[a] = |mag[a][N-1:FAR_BIT];
      end
    end
  end else begin : g_near
    assign axis_far = '0;
  end

  logic [MAG_BITS-1:0] s2_mag [3];
  biso_flags_t         s2_flg;

  always_ff @(posedge clk) begin
    if (rdy2) begin
      for (int a = 0; a < 3; a++) begin
        s2_mag[a] <= mag[a][MAG_BITS-1:0];
      end
      s2_flg.box    <= s1_box;
      s2_flg.in_box <= &axis_in;
      s2_flg.far    <= |axis_far;
    end
  end

  // ------------------------------------------------------ stage 3: squares
  logic [2*MAG_BITS-1:0] s3_sq [3];
  biso_flags_t           s3_flg;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      for (int a = 0; a < 3; a++) begin
        s3_sq[a] <= s2_mag[a] * s2_mag[a];
      end
      s3_flg <= s2_flg;
    end
  end

  // ---------------------------------------------------------- stage 4: sum
  logic [SUM_BITS-1:0] s4_sum;
  biso_flags_t         s4_flg;

  always_ff @(posedge clk) begin
    if (rdy4) begin
      s4_sum <= SUM_BITS'(s3_sq[0]) + SUM_BITS'(s3_sq[1]) + SUM_BITS'(s3_sq[2]);
      s4_flg <= s3_flg;
    end
  end

  // ------------------------------------- square root of sum in Q.8, floored
  logic [ROOT_BITS-1:0] sq_root;
  biso_flags_t          sq_flg;

  biso_sqrt #(
    .RAD_BITS (RAD_BITS)
  ) u_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .rad       ({s4_sum, 8'd0}),
    .in_flags  (s4_flg),
    .in_ready  (sq_in_ready),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_flags (sq_flg),
    .out_ready (rdy5)
  );

  // ------------------------------------- stage 5: distance minus radius, Q.8
  logic signed [DIFF_BITS-1:0] s5_diff;
  biso_flags_t                 s5_flg;

  always_ff @(posedge clk) begin
    if (rdy5) begin
      s5_diff <= $signed(DIFF_BITS'(sq_root) - DIFF_BITS'({brush_radius, 4'd0}));
      s5_flg  <= sq_flg;
    end
  end

  // ------------------------------------------------ stage 6: gain, Q.16
  logic signed [PROD_BITS-1:0] s6_prod;
  biso_flags_t                 s6_flg;

  always_ff @(posedge clk) begin
    if (rdy6) begin
      s6_prod <= s5_diff * $signed({1'b0, gain});
      s6_flg  <= s5_flg;
    end
  end

  // ---------------------------------- stage 7: truncate toward zero to integer
  logic signed [PROD_BITS-1:0] biased;
  logic signed [Q_BITS-1:0]    s7_q;
  biso_flags_t                 s7_flg;

  // add 2^16-1 to negative products so the arithmetic shift rounds toward zero
  assign biased = s6_prod + $signed({{(PROD_BITS-16){1'b0}}, {16{s6_prod[PROD_BITS-1]}}});

  always_ff @(posedge clk) begin
    if (rdy7) begin
      s7_q   <= biased[PROD_BITS-1:16];
      s7_flg <= s6_flg;
    end
  end

  // ---------------------------------------------- output: select and saturate
  logic signed [7:0] iso_next;

  always_comb begin
    if (s7_flg.box) begin
      iso_next = s7_flg.in_box ? ISO_BOX_IN : ISO_MAX;
    end else if (gain == 16'd0) begin
      iso_next = ISO_ZERO;
    end else if (s7_flg.far) begin
      iso_next = ISO_MAX;
    end else if (s7_q > Q_MAX) begin
      iso_next = ISO_MAX;
    end else if (s7_q < Q_MIN) begin
      iso_next = ISO_MIN;
    end else begin
      iso_next = s7_q[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out) begin
      iso <= iso_next;
    end
  end

endmodule

// ----- rtl/core/biso_checker.sv -----
// Port-level checks of the brush isovalue block and their binding.
module biso_checker import biso_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic signed [COORD_BITS-1:0] px,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic signed [7:0]            iso
);

  // hold a stalled sample and its px coordinate
  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_stall) |=> (in_valid && $stable(px)))
    else $error("stalled sample changed or dropped");

  // hold a stalled result and its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(iso)))
    else $error("stalled result changed or dropped");

  // never emit the one code outside the saturation range
  a_iso_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (iso != 8'sh80))
    else $error("isovalue outside -127..127");

  // a free output register lets the whole pipeline advance
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    (!out_valid || !out_stall) |-> !in_stall)
    else $error("input stalled while the output can transfer");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind brush_isovalue_top biso_checker #(.COORD_BITS(COORD_BITS)) u_biso_checker (.*);
